// ===== design/point_in_tetrahedron_test_defines.svh =====
`ifndef POINT_IN_TETRAHEDRON_TEST_DEFINES_SVH
`define POINT_IN_TETRAHEDRON_TEST_DEFINES_SVH

// same-cycle implication
`define PIT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("point_in_tetrahedron_test: check failed");

// next-cycle implication
`define PIT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("point_in_tetrahedron_test: check failed");

`endif

// ===== design/pit_pkg.sv =====
package pit_pkg;

    localparam int REG_BITS      = 63;
    localparam int ORIENT_STAGES = 6;
    localparam int DECIDE_STAGES = 2;
    localparam int PIPE_STAGES   = ORIENT_STAGES + DECIDE_STAGES;

    typedef logic [2:0] reg_idx_t;

    localparam reg_idx_t REG_VERTEX_A = 3'd0;
    localparam reg_idx_t REG_VERTEX_B = 3'd1;
    localparam reg_idx_t REG_VERTEX_C = 3'd2;
    localparam reg_idx_t REG_VERTEX_D = 3'd3;
    localparam reg_idx_t REG_FACE_TOL = 3'd4;

    typedef struct packed {
        logic inside_res;
        logic degenerate;
    } pit_result_t;

endpackage

// ===== design/point_in_tetrahedron_test.sv =====
// point-in-tetrahedron test, one point per clock
//
// the four vertices and the face tolerance are written through the plain
// write port (wr_en, wr_index, wr_data); the user must do so only while no
// point is in flight, the block does not enforce it; indexes 0 to 3 are
// vertices a to d, index 4 the tolerance, other indexes are ignored; a point
// word is taken at each rising edge with start high; busy stays low, so a new
// word may enter every cycle; the result word shows on inside_res and
// degenerate for one cycle with done high
// throughput is one word per cycle; the path runs through the six-stage
// orientation pipeline (edge vectors, cross products, cross differences,
// split dot products, term merge, sum) and two stages of sign and tolerance
// checks
// reset clears the vertices, the tolerance and every in-flight valid bit
// the receiver cannot stall: results are never held back
module point_in_tetrahedron_test #(
    parameter int COORD_BITS = 21
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [COORD_BITS-1:0] point_x,
    input  logic signed [COORD_BITS-1:0] point_y,
    input  logic signed [COORD_BITS-1:0] point_z,
    input  logic                         wr_en,
    input  pit_pkg::reg_idx_t            wr_index,
    input  logic [pit_pkg::REG_BITS-1:0] wr_data,
    output logic                         done,
    output logic                         inside_res,
    output logic                         degenerate
);
    import pit_pkg::*;

    localparam int VW = 3 * COORD_BITS;
    localparam int OW = 3 * COORD_BITS + 6;

    logic [VW-1:0]          vertex_reg [4];
    logic [REG_BITS-1:0]    tol_reg;
    logic [PIPE_STAGES-1:0] valid_reg;

    logic [VW-1:0]          vertex_next [4];
    logic [REG_BITS-1:0]    tol_next;
    logic [PIPE_STAGES-1:0] valid_next;

    logic                          accept;
    logic signed [COORD_BITS-1:0]  a_pt [3];
    logic signed [COORD_BITS-1:0]  b_pt [3];
    logic signed [COORD_BITS-1:0]  c_pt [3];
    logic signed [COORD_BITS-1:0]  d_pt [3];
    logic signed [COORD_BITS-1:0]  p_pt [3];
    logic signed [OW-1:0]          orient_val [5];
    pit_result_t                   res;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // register writes
    always_comb
    begin
        vertex_next = vertex_reg;
        tol_next    = tol_reg;
        if (wr_en)
        begin
            case (wr_index)
                REG_VERTEX_A: vertex_next[0] = wr_data[VW-1:0];
                REG_VERTEX_B: vertex_next[1] = wr_data[VW-1:0];
                REG_VERTEX_C: vertex_next[2] = wr_data[VW-1:0];
                REG_VERTEX_D: vertex_next[3] = wr_data[VW-1:0];
                REG_FACE_TOL: tol_next       = wr_data;
                default:      ;
            endcase
        end
    end

    assign valid_next = {valid_reg[PIPE_STAGES-2:0], accept};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
            begin
                vertex_reg[i] <= '0;
            end
            tol_reg   <= '0;
            valid_reg <= '0;
        end
        else
        begin
            vertex_reg <= vertex_next;
            tol_reg    <= tol_next;
            valid_reg  <= valid_next;
        end
    end

    // unpack vertex coordinates
    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            a_pt[j] = $signed(vertex_reg[0][j*COORD_BITS +: COORD_BITS]);
            b_pt[j] = $signed(vertex_reg[1][j*COORD_BITS +: COORD_BITS]);
            c_pt[j] = $signed(vertex_reg[2][j*COORD_BITS +: COORD_BITS]);
            d_pt[j] = $signed(vertex_reg[3][j*COORD_BITS +: COORD_BITS]);
        end
        p_pt[0] = point_x;
        p_pt[1] = point_y;
        p_pt[2] = point_z;
    end

    // reference orientation
    pit_orient #(.COORD_BITS(COORD_BITS)) u_orient_ref (
        .clk        (clk),
        .p0         (d_pt),
        .p1         (a_pt),
        .p2         (b_pt),
        .p3         (c_pt),
        .orient_val (orient_val[0])
    );

    pit_orient #(.COORD_BITS(COORD_BITS)) u_orient_a (
        .clk        (clk),
        .p0         (d_pt),
        .p1         (p_pt),
        .p2         (b_pt),
        .p3         (c_pt),
        .orient_val (orient_val[1])
    );

    pit_orient #(.COORD_BITS(COORD_BITS)) u_orient_b (
        .clk        (clk),
        .p0         (d_pt),
        .p1         (a_pt),
        .p2         (p_pt),
        .p3         (c_pt),
        .orient_val (orient_val[2])
    );

    pit_orient #(.COORD_BITS(COORD_BITS)) u_orient_c (
        .clk        (clk),
        .p0         (d_pt),
        .p1         (a_pt),
        .p2         (b_pt),
        .p3         (p_pt),
        .orient_val (orient_val[3])
    );

    pit_orient #(.COORD_BITS(COORD_BITS)) u_orient_d (
        .clk        (clk),
        .p0         (p_pt),
        .p1         (a_pt),
        .p2         (b_pt),
        .p3         (c_pt),
        .orient_val (orient_val[4])
    );

    pit_decide #(.COORD_BITS(COORD_BITS)) u_decide (
        .clk        (clk),
        .orient_val (orient_val),
        .tol        (tol_reg),
        .result     (res)
    );

    assign done       = valid_reg[PIPE_STAGES-1];
    assign inside_res = res.inside_res;
    assign degenerate = res.degenerate;

endmodule

// ===== design/pit_orient.sv =====
module pit_orient #(
    parameter int COORD_BITS = 21
) (
    input  logic                          clk,
    input  logic signed [COORD_BITS-1:0]  p0 [3],
    input  logic signed [COORD_BITS-1:0]  p1 [3],
    input  logic signed [COORD_BITS-1:0]  p2 [3],
    input  logic signed [COORD_BITS-1:0]  p3 [3],
    output logic signed [3*COORD_BITS+5:0] orient_val
);
    import pit_pkg::*;

    localparam int DW  = COORD_BITS + 1;
    localparam int PW  = 2 * COORD_BITS + 2;
    localparam int XW  = 2 * COORD_BITS + 3;
    localparam int K   = COORD_BITS + 1;
    localparam int HW  = XW - K;
    localparam int HPW = HW + DW;
    localparam int LPW = K + 1 + DW;
    localparam int OW  = 3 * COORD_BITS + 6;

    logic signed [DW-1:0]  u_reg [3];
    logic signed [DW-1:0]  v_reg [3];
    logic signed [DW-1:0]  w1_reg [3];
    logic signed [DW-1:0]  w2_reg [3];
    logic signed [DW-1:0]  w3_reg [3];
    logic signed [PW-1:0]  m_reg [6];
    logic signed [XW-1:0]  cr_reg [3];
    logic signed [HPW-1:0] ph_reg [3];
    logic signed [LPW-1:0] pl_reg [3];
    logic signed [OW-1:0]  t_reg [3];
    logic signed [OW-1:0]  o_reg;

    logic signed [DW-1:0]  u_next [3];
    logic signed [DW-1:0]  v_next [3];
    logic signed [DW-1:0]  w1_next [3];
    logic signed [PW-1:0]  m_next [6];
    logic signed [XW-1:0]  cr_next [3];
    logic signed [HPW-1:0] ph_next [3];
    logic signed [LPW-1:0] pl_next [3];
    logic signed [OW-1:0]  t_next [3];
    logic signed [OW-1:0]  o_next;

    // edge vectors
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            u_next[i]  = DW'(p0[i]) - DW'(p1[i]);
            v_next[i]  = DW'(p0[i]) - DW'(p2[i]);
            w1_next[i] = DW'(p0[i]) - DW'(p3[i]);
        end
    end

    // cross product terms
    always_comb
    begin
        m_next[0] = PW'(u_reg[1]) * PW'(v_reg[2]);
        m_next[1] = PW'(u_reg[2]) * PW'(v_reg[1]);
        m_next[2] = PW'(u_reg[2]) * PW'(v_reg[0]);
        m_next[3] = PW'(u_reg[0]) * PW'(v_reg[2]);
        m_next[4] = PW'(u_reg[0]) * PW'(v_reg[1]);
        m_next[5] = PW'(u_reg[1]) * PW'(v_reg[0]);
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            cr_next[i] = XW'(m_reg[2*i]) - XW'(m_reg[2*i+1]);
        end
    end

    // dot product, cross term split into signed high and unsigned low halves
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            ph_next[i] = HPW'($signed(cr_reg[i][XW-1:K])) * HPW'(w3_reg[i]);
            pl_next[i] = LPW'($signed({1'b0, cr_reg[i][K-1:0]})) * LPW'(w3_reg[i]);
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            t_next[i] = (OW'(ph_reg[i]) <<< K) + OW'(pl_reg[i]);
        end
        o_next = t_reg[0] + t_reg[1] + t_reg[2];
    end

    always_ff @(posedge clk)
    begin
        u_reg  <= u_next;
        v_reg  <= v_next;
        w1_reg <= w1_next;
        m_reg  <= m_next;
        w2_reg <= w1_reg;
        cr_reg <= cr_next;
        w3_reg <= w2_reg;
        ph_reg <= ph_next;
        pl_reg <= pl_next;
        t_reg  <= t_next;
        o_reg  <= o_next;
    end

    assign orient_val = o_reg;

endmodule

// ===== design/pit_decide.sv =====
module pit_decide #(
    parameter int COORD_BITS = 21
) (
    input  logic                           clk,
    input  logic signed [3*COORD_BITS+5:0] orient_val [5],
    input  logic [pit_pkg::REG_BITS-1:0]   tol,
    output pit_pkg::pit_result_t           result
);
    import pit_pkg::*;

    localparam int OW = 3 * COORD_BITS + 6;
    localparam int CW = (OW > REG_BITS) ? OW : REG_BITS;

    logic [4:0]    neg_reg;
    logic [OW-1:0] mag_reg [4];
    logic          zero_reg;
    pit_result_t   result_reg;

    logic [4:0]    neg_next;
    logic [OW-1:0] mag_next [4];
    logic          zero_next;
    logic          ok_all;
    pit_result_t   result_next;

    // sign of each orientation, magnitude of the four face orientations
    always_comb
    begin
        for (int i = 0; i < 5; i++)
        begin
            neg_next[i] = orient_val[i][OW-1];
        end
        for (int i = 0; i < 4; i++)
        begin
            mag_next[i] = neg_next[i+1] ? $unsigned(-orient_val[i+1])
                                        : $unsigned(orient_val[i+1]);
        end
        zero_next = (orient_val[0] == '0);
    end

    // each face: same side as reference or within tolerance
    always_comb
    begin
        ok_all = 1'b1;
        for (int i = 0; i < 4; i++)
        begin
            if (!((neg_reg[i+1] == neg_reg[0]) || (CW'(mag_reg[i]) < CW'(tol))))
            begin
                ok_all = 1'b0;
            end
        end
        result_next.inside_res = !zero_reg && ok_all;
        result_next.degenerate = zero_reg;
    end

    always_ff @(posedge clk)
    begin
        neg_reg    <= neg_next;
        mag_reg    <= mag_next;
        zero_reg   <= zero_next;
        result_reg <= result_next;
    end

    assign result = result_reg;

endmodule

// ===== design/pit_checker.sv =====
`include "point_in_tetrahedron_test_defines.svh"

module pit_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done,
    input logic inside_res,
    input logic degenerate
);
    import pit_pkg::*;

    // every result word traces back to a taken point
    `PIT_ASSERT_NOW(a_done_from_start, done, $past(start && !busy, PIPE_STAGES))

    // every taken point yields a result word
    `PIT_ASSERT_NEXT(a_start_to_done, start && !busy, ##(PIPE_STAGES-1) done)

    // a flat tetrahedron never reports inside
    `PIT_ASSERT_NOW(a_degen_not_inside, done && degenerate, !inside_res)

    // nothing in flight right after reset
    `PIT_ASSERT_NOW(a_quiet_after_reset, $rose(rst_n), !done)

endmodule

bind point_in_tetrahedron_test pit_checker u_pit_checker (.*);
